// ===== rtl/core/url_query_string_parser_defines.svh =====
// ----------------------------------------------------------------------------
// URL query string parser - assertion macros
// Shared macros for concurrent assertions; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef URL_QUERY_STRING_PARSER_DEFINES_SVH
`define URL_QUERY_STRING_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property, sampled on the rising clock, off during reset
`define UPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Same-cycle implication
`define UPS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define UPS_ASSERT(lbl, clk, rstn, prop, msg)
`define UPS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/core/ups_pkg.sv =====
// ----------------------------------------------------------------------------
// URL query string parser - package
// Result codes, error codes, delimiter bytes and shared structs.
// ----------------------------------------------------------------------------
package ups_pkg;

  // Delimiters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_AMP = 8'h26;  // '&'
  localparam logic [7:0] CH_EQ  = 8'h3d;  // '='

  // Widest lane index / name position carried between modules
  localparam int unsigned LANE_W = 6;
  localparam int unsigned POS_W  = 6;

  typedef enum logic [3:0] {
    KIND_NAME      = 4'd0,
    KIND_VALUE     = 4'd1,
    KIND_NAME_END  = 4'd2,
    KIND_PAIR_END  = 4'd3,
    KIND_PAIR_DONE = 4'd4,
    KIND_SKIP      = 4'd5,
    KIND_EMPTY_END = 4'd6,
    KIND_ERROR     = 4'd7,
    KIND_IGNORED   = 4'd8
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_END_IN_NAME = 4'd1,
    ERR_AMP_IN_NAME = 4'd2,
    ERR_EMPTY_NAME  = 4'd3,
    ERR_DUPLICATE   = 4'd4,
    ERR_EQ_IN_VALUE = 4'd5,
    ERR_BAD_CHAR    = 4'd6,
    ERR_NAME_LONG   = 4'd7,
    ERR_TOO_MANY    = 4'd8
  } err_e;

  // One tagged result
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [3:0]  pair_index;
    err_e        err;
    logic        query_end;
  } result_t;

  // Writes into the name store
  typedef struct packed {
    logic              name_we;
    logic              len_we;
    logic [LANE_W-1:0] lane;
    logic [POS_W-1:0]  pos;
    logic [7:0]        data;
    logic [POS_W-1:0]  len;
  } store_wr_t;

  // Letters, digits and the URL punctuation set
  function automatic logic is_allowed(logic [7:0] c);
    logic ok;
    ok = 1'b0;
    case (c) inside
      ["a":"z"], ["A":"Z"], ["0":"9"]: ok = 1'b1;
      "/", "?", ":", "@", "-", ".", "_", "~", "%", "!",
      "$", "&", "'", "(", ")", "*", "+", ",", ";", "=": ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ===== rtl/core/ups_name_store.sv =====
// ----------------------------------------------------------------------------
// URL query string parser - name store
// Stored names as a row memory (one row per name position, one byte lane
// per pair), plus per-pair name lengths; compares all lanes in parallel.
// ----------------------------------------------------------------------------
module ups_name_store #(
  parameter int unsigned MAX_FIELDS   = 16,
  parameter int unsigned MAX_NAME_LEN = 32
) (
  input  logic                                 clk_i,
  input  ups_pkg::store_wr_t                   wr_i,
  input  logic [$clog2(MAX_NAME_LEN+1)-1:0]    rd_pos_i,
  input  logic [$clog2(MAX_NAME_LEN+1)-1:0]    cmp_pos_i,
  input  logic [7:0]                           cmp_byte_i,
  output logic [MAX_FIELDS-1:0]                byte_miss_o,
  output logic [MAX_FIELDS-1:0]                len_miss_o
);

  localparam int unsigned NLW = $clog2(MAX_NAME_LEN + 1);
  localparam int unsigned AW  = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int unsigned LW  = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int unsigned RW  = MAX_FIELDS * 8;

  logic [RW-1:0]  mem_q [MAX_NAME_LEN];
  logic [RW-1:0]  row_q;
  logic [NLW-1:0] len_q [MAX_FIELDS];
  logic [AW-1:0]  rd_addr;

  // Positions at or past the limit never compare; park the read on row 0
  assign rd_addr = (rd_pos_i < NLW'(MAX_NAME_LEN)) ? rd_pos_i[AW-1:0] : '0;

  // Row memory: byte-lane write, registered read of the next position
  always_ff @(posedge clk_i) begin
    if (wr_i.name_we) begin
      mem_q[wr_i.pos[AW-1:0]][{wr_i.lane[LW-1:0], 3'b000} +: 8] <= wr_i.data;
    end
    row_q <= mem_q[rd_addr];
  end

  // Name lengths, one register per pair
  always_ff @(posedge clk_i) begin
    if (wr_i.len_we) begin
      len_q[wr_i.lane[LW-1:0]] <= NLW'(wr_i.len);
    end
  end

  // Per-lane mismatch against the byte at the current position
  always_comb begin
    for (int i = 0; i < MAX_FIELDS; i++) begin
      byte_miss_o[i] = (len_q[i] <= cmp_pos_i) || (row_q[i*8 +: 8] != cmp_byte_i);
      len_miss_o[i]  = (len_q[i] != cmp_pos_i);
    end
  end

endmodule

// ===== rtl/core/ups_parser.sv =====
// ----------------------------------------------------------------------------
// URL query string parser - parse step
// Per-query state and the byte classification for one byte per cycle while step_i is high.
// ----------------------------------------------------------------------------
module ups_parser #(
  parameter int unsigned MAX_FIELDS   = 16,
  parameter int unsigned MAX_NAME_LEN = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic [7:0]                        ch_i,
  input  logic [MAX_FIELDS-1:0]             byte_miss_i,
  input  logic [MAX_FIELDS-1:0]             len_miss_i,
  output ups_pkg::result_t                  res_o,
  output ups_pkg::store_wr_t                wr_o,
  output logic [$clog2(MAX_NAME_LEN+1)-1:0] rd_pos_o
);

  localparam int unsigned NLW = $clog2(MAX_NAME_LEN + 1);
  localparam int unsigned PCW = $clog2(MAX_FIELDS + 1);

  logic                  in_value_q, in_value_d;
  logic [NLW-1:0]        nl_q, nl_d;
  logic [PCW-1:0]        pc_q, pc_d;
  logic [MAX_FIELDS-1:0] mv_q, mv_d;
  logic                  failed_q, failed_d;
  logic [MAX_FIELDS-1:0] below;
  logic                  is_end;
  ups_pkg::store_wr_t    wr;

  assign is_end = (ch_i == ups_pkg::CH_NUL);

  // Lanes that hold a finished name of this query
  always_comb begin
    for (int i = 0; i < MAX_FIELDS; i++) begin
      below[i] = (PCW'(i) < pc_q);
    end
  end

  // Classify the byte and work out the next state
  always_comb begin
    in_value_d = in_value_q;
    nl_d       = nl_q;
    pc_d       = pc_q;
    mv_d       = mv_q;
    failed_d   = failed_q;
    wr         = '0;
    wr.lane    = ups_pkg::LANE_W'(pc_q);
    wr.pos     = ups_pkg::POS_W'(nl_q);
    wr.data    = ch_i;
    wr.len     = ups_pkg::POS_W'(nl_q);

    res_o.kind       = ups_pkg::KIND_NAME;
    res_o.data       = ch_i;
    res_o.pair_index = 4'(pc_q);
    res_o.err        = ups_pkg::ERR_NONE;
    res_o.query_end  = is_end;

    if (failed_q) begin
      res_o.kind       = ups_pkg::KIND_IGNORED;
      res_o.pair_index = '0;
    end else if (!in_value_q) begin
      if (is_end) begin
        if (nl_q == '0) res_o.kind = ups_pkg::KIND_EMPTY_END;
        else            res_o.err  = ups_pkg::ERR_END_IN_NAME;
      end else if (ch_i == ups_pkg::CH_AMP) begin
        if (nl_q == '0) res_o.kind = ups_pkg::KIND_SKIP;
        else            res_o.err  = ups_pkg::ERR_AMP_IN_NAME;
      end else if (ch_i == ups_pkg::CH_EQ) begin
        if (nl_q == '0) begin
          res_o.err = ups_pkg::ERR_EMPTY_NAME;
        end else begin
          res_o.kind = ups_pkg::KIND_NAME_END;
          wr.len_we  = 1'b1;
          mv_d       = mv_q & ~len_miss_i;
          in_value_d = 1'b1;
        end
      end else if (!ups_pkg::is_allowed(ch_i)) begin
        res_o.err = ups_pkg::ERR_BAD_CHAR;
      end else if (nl_q >= NLW'(MAX_NAME_LEN)) begin
        res_o.err = ups_pkg::ERR_NAME_LONG;
      end else if (nl_q == '0 && pc_q >= PCW'(MAX_FIELDS)) begin
        res_o.err = ups_pkg::ERR_TOO_MANY;
      end else begin
        // first byte of a name arms all earlier names as candidates
        mv_d       = ((nl_q == '0) ? below : mv_q) & ~byte_miss_i;
        wr.name_we = 1'b1;
        nl_d       = nl_q + NLW'(1);
      end
    end else begin
      if (is_end || ch_i == ups_pkg::CH_AMP) begin
        if (mv_q != '0) begin
          res_o.err = ups_pkg::ERR_DUPLICATE;
        end else begin
          res_o.kind = is_end ? ups_pkg::KIND_PAIR_DONE : ups_pkg::KIND_PAIR_END;
          pc_d       = pc_q + PCW'(1);
          in_value_d = 1'b0;
          nl_d       = '0;
          mv_d       = '0;
        end
      end else if (ch_i == ups_pkg::CH_EQ) begin
        res_o.err = ups_pkg::ERR_EQ_IN_VALUE;
      end else if (!ups_pkg::is_allowed(ch_i)) begin
        res_o.err = ups_pkg::ERR_BAD_CHAR;
      end else begin
        res_o.kind = ups_pkg::KIND_VALUE;
      end
    end

    if (res_o.err != ups_pkg::ERR_NONE) begin
      res_o.kind = ups_pkg::KIND_ERROR;
      if (!is_end) failed_d = 1'b1;
    end

    // zero byte closes the query
    if (is_end) begin
      in_value_d = 1'b0;
      nl_d       = '0;
      pc_d       = '0;
      mv_d       = '0;
      failed_d   = 1'b0;
    end
  end

  // Store writes only on a real transfer
  always_comb begin
    wr_o         = wr;
    wr_o.name_we = wr.name_we & step_i;
    wr_o.len_we  = wr.len_we & step_i;
  end

  // Read ahead the row for the position the next byte will use
  assign rd_pos_o = step_i ? nl_d : nl_q;

  // Query state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_value_q <= 1'b0;
      nl_q       <= '0;
      pc_q       <= '0;
      mv_q       <= '0;
      failed_q   <= 1'b0;
    end else if (step_i) begin
      in_value_q <= in_value_d;
      nl_q       <= nl_d;
      pc_q       <= pc_d;
      mv_q       <= mv_d;
      failed_q   <= failed_d;
    end
  end

endmodule

// ===== rtl/core/url_query_string_parser.sv =====
// ----------------------------------------------------------------------------
// URL query string parser - top level
// Tags each query byte as name, value, delimiter, error or ignored, with its pair index.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one query byte per transfer in s_axis_tdata_i; a zero
//   byte ends the query. Master side gives one result per byte: the kind in
//   m_axis_tuser_o, byte, pair index and error code in m_axis_tdata_o, and
//   tlast on the result for the zero byte.
//   Each byte is held in the input register, then its result in the result
//   register. Throughput is one byte per cycle while the master side takes
//   results; the duplicate-name check compares all stored names at once,
//   from one row of the name memory that is registered ahead of its byte.
//   Reset clears the query state at once; the name memory is not cleared
//   and needs no sweep, as a stored name is read only after it is written.
//   When the master side stalls, the result and the byte in the input
//   register hold, and s_axis_tready_o drops while both are full.
// ----------------------------------------------------------------------------
`include "url_query_string_parser_defines.svh"

module url_query_string_parser #(
  parameter int unsigned MAX_FIELDS   = 16,
  parameter int unsigned MAX_NAME_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] byte_out, [11:8] pair_index,
                                        // [15:12] error_code
  output logic [3:0]  m_axis_tuser_o,   // [3:0] kind
  output logic        m_axis_tlast_o    // query_end
);

  localparam int unsigned NLW = $clog2(MAX_NAME_LEN + 1);

  logic                  in_valid_q;
  logic [7:0]            ch_q;
  logic                  out_valid_q;
  ups_pkg::result_t      out_res_q;
  ups_pkg::result_t      res;
  ups_pkg::store_wr_t    wr;
  logic [NLW-1:0]        rd_pos;
  logic [MAX_FIELDS-1:0] byte_miss;
  logic [MAX_FIELDS-1:0] len_miss;
  logic                  step;

  // Advance when the result register is free or being emptied
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (step)                 out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  // Input and result payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) ch_q <= s_axis_tdata_i;
    if (step) out_res_q <= res;
  end

  ups_parser #(
    .MAX_FIELDS  (MAX_FIELDS),
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .ch_i       (ch_q),
    .byte_miss_i(byte_miss),
    .len_miss_i (len_miss),
    .res_o      (res),
    .wr_o       (wr),
    .rd_pos_o   (rd_pos)
  );

  ups_name_store #(
    .MAX_FIELDS  (MAX_FIELDS),
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) u_name_store (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .rd_pos_i   (rd_pos),
    .cmp_pos_i  (NLW'(wr.pos)),
    .cmp_byte_i (ch_q),
    .byte_miss_o(byte_miss),
    .len_miss_o (len_miss)
  );

  // Output packing
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.err, out_res_q.pair_index, out_res_q.data};
  assign m_axis_tuser_o  = out_res_q.kind;
  assign m_axis_tlast_o  = out_res_q.query_end;

  // Checks
  `UPS_ASSERT_IMPLY(a_err_kind, clk_i, rst_ni, out_valid_q,
    (out_res_q.kind == ups_pkg::KIND_ERROR) == (out_res_q.err != ups_pkg::ERR_NONE),
    "error code and error kind disagree")
  `UPS_ASSERT_IMPLY(a_ignored, clk_i, rst_ni,
    out_valid_q && out_res_q.kind == ups_pkg::KIND_IGNORED,
    out_res_q.pair_index == '0 && out_res_q.err == ups_pkg::ERR_NONE,
    "ignored result carries index or error")
  `UPS_ASSERT(a_end_flag, clk_i, rst_ni,
    step && ch_q == ups_pkg::CH_NUL |=> out_valid_q && out_res_q.query_end,
    "zero byte result lacks query end")
  `UPS_ASSERT(a_in_hold, clk_i, rst_ni,
    in_valid_q && !step |=> in_valid_q && $stable(ch_q),
    "held input byte lost")

endmodule

// ===== sim/url_query_string_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL query string parser - testbench
// Feeds query strings byte by byte: a short directed set, then random
// queries, mostly well formed with random names and values, plus broken
// queries and byte noise. A byte-level predictor tags every accepted byte
// and the monitor checks each result transfer against it, in order.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module url_query_string_parser_tb;

  localparam int unsigned MAX_FIELDS   = 16;
  localparam int unsigned MAX_NAME_LEN = 32;
  localparam int TOTAL_BYTES  = 1750;
  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer at all
  localparam int HOLD_AT      = 400;   // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  url_query_string_parser #(
    .MAX_FIELDS  (MAX_FIELDS),
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stimulus and scoreboard storage
  logic [7:0]       query_bytes[$];
  ups_pkg::result_t tagged_bytes[$];
  string            url_marks = "/?:@-._~%!$&'()*+,;=";

  int bytes_sent     = 0;
  int bytes_accepted = 0;
  int results_seen   = 0;
  int queries_built  = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;
  int drain_at       = 0;
  int send_gap       = 0;
  int ready_gap      = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  bit [8:0] kinds_seen = '0;
  bit [8:0] codes_seen = '0;

  // Parser shadow state
  bit       pv_in_value = 1'b0;
  int       pv_name_len = 0;
  int       pv_pairs    = 0;
  bit [7:0] pv_names[MAX_FIELDS][MAX_NAME_LEN];
  int       pv_name_lens[MAX_FIELDS];
  bit [MAX_FIELDS-1:0] pv_match = '0;
  bit       pv_failed   = 1'b0;

  function automatic bit url_char_ok(logic [7:0] c);
    bit ok;
    ok = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
    for (int i = 0; i < url_marks.len(); i++)
      if (c == url_marks[i]) ok = 1'b1;
    return ok;
  endfunction

  // Tag one byte and advance the shadow state
  function automatic ups_pkg::result_t parse_query_byte(logic [7:0] c);
    ups_pkg::result_t r;
    bit               at_end;
    at_end       = (c == ups_pkg::CH_NUL);
    r.kind       = ups_pkg::KIND_NAME;
    r.data       = c;
    r.pair_index = pv_pairs[3:0];
    r.err        = ups_pkg::ERR_NONE;
    r.query_end  = at_end;
    if (pv_failed) begin
      r.kind       = ups_pkg::KIND_IGNORED;
      r.pair_index = '0;
    end else if (!pv_in_value) begin
      if (c == ups_pkg::CH_NUL) begin
        if (pv_name_len == 0) r.kind = ups_pkg::KIND_EMPTY_END;
        else r.err = ups_pkg::ERR_END_IN_NAME;
      end else if (c == ups_pkg::CH_AMP) begin
        if (pv_name_len == 0) r.kind = ups_pkg::KIND_SKIP;
        else r.err = ups_pkg::ERR_AMP_IN_NAME;
      end else if (c == ups_pkg::CH_EQ) begin
        if (pv_name_len == 0) begin
          r.err = ups_pkg::ERR_EMPTY_NAME;
        end else begin
          r.kind = ups_pkg::KIND_NAME_END;
          pv_name_lens[pv_pairs] = pv_name_len;
          for (int i = 0; i < pv_pairs; i++)
            if (pv_name_lens[i] != pv_name_len) pv_match[i] = 1'b0;
          pv_in_value = 1'b1;
        end
      end else if (!url_char_ok(c)) begin
        r.err = ups_pkg::ERR_BAD_CHAR;
      end else if (pv_name_len >= MAX_NAME_LEN) begin
        r.err = ups_pkg::ERR_NAME_LONG;
      end else if (pv_name_len == 0 && pv_pairs >= MAX_FIELDS) begin
        r.err = ups_pkg::ERR_TOO_MANY;
      end else begin
        // first byte of a name: every stored name is a candidate
        if (pv_name_len == 0) begin
          pv_match = '0;
          for (int i = 0; i < pv_pairs; i++) pv_match[i] = 1'b1;
        end
        pv_names[pv_pairs][pv_name_len] = c;
        for (int i = 0; i < pv_pairs; i++)
          if (pv_name_lens[i] <= pv_name_len || pv_names[i][pv_name_len] != c)
            pv_match[i] = 1'b0;
        pv_name_len++;
      end
    end else begin
      if (c == ups_pkg::CH_NUL || c == ups_pkg::CH_AMP) begin
        // duplicate name is reported at the end of its value
        if (pv_match != '0) begin
          r.err = ups_pkg::ERR_DUPLICATE;
        end else begin
          r.kind      = (c == ups_pkg::CH_NUL) ? ups_pkg::KIND_PAIR_DONE
                                               : ups_pkg::KIND_PAIR_END;
          pv_pairs++;
          pv_in_value = 1'b0;
          pv_name_len = 0;
          pv_match    = '0;
        end
      end else if (c == ups_pkg::CH_EQ) begin
        r.err = ups_pkg::ERR_EQ_IN_VALUE;
      end else if (!url_char_ok(c)) begin
        r.err = ups_pkg::ERR_BAD_CHAR;
      end else begin
        r.kind = ups_pkg::KIND_VALUE;
      end
    end
    if (r.err != ups_pkg::ERR_NONE) begin
      r.kind = ups_pkg::KIND_ERROR;
      if (!at_end) pv_failed = 1'b1;
    end
    // zero byte always starts a fresh query
    if (at_end) begin
      pv_in_value = 1'b0;
      pv_name_len = 0;
      pv_pairs    = 0;
      pv_match    = '0;
      pv_failed   = 1'b0;
    end
    return r;
  endfunction

  // Idle length: mostly none, some short, a few long; none in calm stretches
  function automatic int idle_len();
    int r;
    if ((bytes_accepted / 128) % 5 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Query building
  task automatic add_byte(logic [7:0] c);
    query_bytes.insert(query_bytes.size(), c);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) query_bytes.insert(query_bytes.size(), s[i]);
  endtask

  // Any allowed byte except the two delimiters
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    int         r;
    do begin
      r = $urandom_range(0, 9);
      if (r < 3)      c = 8'("a" + $urandom_range(0, 25));
      else if (r < 5) c = 8'("A" + $urandom_range(0, 25));
      else if (r < 7) c = 8'("0" + $urandom_range(0, 9));
      else            c = url_marks[$urandom_range(0, url_marks.len() - 1)];
    end while (c == ups_pkg::CH_AMP || c == ups_pkg::CH_EQ);
    return c;
  endfunction

  // Short names over a tiny alphabet give shared prefixes and equal lengths
  function automatic string fresh_name();
    string s;
    int    r;
    int    n;
    s = "";
    r = $urandom_range(0, 99);
    if (r < 50) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        s = $sformatf("%s%c", s, ($urandom_range(0, 1) ? "a" : "b"));
    end else begin
      n = (r < 95) ? $urandom_range(1, 6)
                   : $urandom_range(MAX_NAME_LEN - 3, MAX_NAME_LEN + 1);
      for (int i = 0; i < n; i++) s = $sformatf("%s%c", s, plain_char());
    end
    return s;
  endfunction

  task automatic add_pairs(int n_pairs, bit allow_dup);
    string used[$];
    string name;
    bit    clash;
    int    vlen;
    for (int p = 0; p < n_pairs; p++) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 2)) add_byte(ups_pkg::CH_AMP);
      if (allow_dup && used.size() > 0 && $urandom_range(0, 99) < 12) begin
        name = used[$urandom_range(0, used.size() - 1)];
      end else begin
        do begin
          name  = fresh_name();
          clash = 1'b0;
          foreach (used[i]) if (used[i] == name) clash = 1'b1;
        end while (clash);
      end
      used.insert(used.size(), name);
      add_text(name);
      add_byte(ups_pkg::CH_EQ);
      vlen = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      repeat (vlen) add_byte(plain_char());
      if (p < n_pairs - 1) add_byte(ups_pkg::CH_AMP);
    end
    if ($urandom_range(0, 9) == 0) add_byte(ups_pkg::CH_AMP);
    add_byte(ups_pkg::CH_NUL);
    queries_built++;
  endtask

  // Sender: one byte offered at a time, random gaps between bytes
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_tvalid || bytes_accepted == bytes_sent) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (bytes_sent == drain_at && tagged_bytes.size() != 0) begin
          // mid-run pause until every pending result is out
          s_tvalid <= 1'b0;
        end else if (query_bytes.size() != 0) begin
          s_tdata  <= query_bytes.pop_front();
          s_tvalid <= 1'b1;
          bytes_sent++;
          send_gap = idle_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off that backs up the input
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        m_tready <= 1'b0;
      end else begin
        ready_gap = idle_len();
        m_tready <= (ready_gap == 0);
      end
    end
  end

  // Monitor: tag accepted bytes, check result transfers, watchdog
  always @(posedge clk_i) begin
    ups_pkg::result_t want;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        tagged_bytes.insert(tagged_bytes.size(), parse_query_byte(s_tdata));
        bytes_accepted++;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (tagged_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected result: kind %0d byte %02h", $realtime, m_tuser,
                     m_tdata[7:0]);
        end else begin
          want = tagged_bytes.pop_front();
          kinds_seen[want.kind] = 1'b1;
          codes_seen[want.err]  = 1'b1;
          if (m_tuser !== want.kind || m_tdata[7:0] !== want.data ||
              m_tdata[11:8] !== want.pair_index || m_tdata[15:12] !== want.err ||
              m_tlast !== want.query_end) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0t] result %0d: exp kind %0d byte %02h idx %0d err %0d last %0b",
                       $realtime, results_seen, want.kind, want.data, want.pair_index,
                       want.err, want.query_end);
              $display("           got kind %0d byte %02h idx %0d err %0d last %0b",
                       m_tuser, m_tdata[7:0], m_tdata[11:8], m_tdata[15:12], m_tlast);
            end
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int first;
    int pick;

    // Directed queries
    add_text("&a=1&&b=");  add_byte(ups_pkg::CH_NUL);  // skip, pairs, empty value
    add_byte(ups_pkg::CH_NUL);                         // empty query
    add_text("a");         add_byte(ups_pkg::CH_NUL);  // end inside a name
    add_text("a&z");       add_byte(ups_pkg::CH_NUL);  // ampersand in name, then ignored
    add_text("=");         add_byte(ups_pkg::CH_NUL);  // empty name
    add_text("a==");       add_byte(ups_pkg::CH_NUL);  // equals inside a value
    add_byte(8'hff);       add_byte(ups_pkg::CH_NUL);  // byte outside the set
    add_text("a=1&a=2");   add_byte(ups_pkg::CH_NUL);  // duplicate found on the zero byte
    queries_built += 8;

    // Random queries
    while (query_bytes.size() < TOTAL_BYTES) begin
      r     = $urandom_range(0, 99);
      first = query_bytes.size();
      if (r < 10) begin
        repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
        add_byte(ups_pkg::CH_NUL);
        queries_built++;
      end else if (r < 20) begin
        add_pairs($urandom_range(MAX_FIELDS - 2, MAX_FIELDS + 1), 1'b0);
      end else begin
        add_pairs($urandom_range(0, 5), 1'b1);
        // broken query: one byte replaced
        if (r < 35 && query_bytes.size() - first >= 2) begin
          pick = $urandom_range(first, query_bytes.size() - 2);
          case ($urandom_range(0, 3))
            0:       query_bytes[pick] = ups_pkg::CH_NUL;
            1:       query_bytes[pick] = ups_pkg::CH_AMP;
            2:       query_bytes[pick] = ups_pkg::CH_EQ;
            default: query_bytes[pick] = 8'($urandom_range(1, 255));
          endcase
        end
      end
      if (drain_at == 0 && query_bytes.size() >= TOTAL_BYTES / 2)
        drain_at = query_bytes.size();
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (query_bytes.size() != 0 || bytes_accepted != bytes_sent || tagged_bytes.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d bytes in %0d queries, %0d results checked, %0d mismatches",
             bytes_accepted, queries_built, results_seen, mismatches);
    $display("Result kinds seen %09b, error codes seen %09b", kinds_seen, codes_seen);
    if (mismatches == 0 && tagged_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ups_pkg.sv
rtl/core/ups_name_store.sv
rtl/core/ups_parser.sv
rtl/core/url_query_string_parser.sv
sim/url_query_string_parser_tb.sv
